/* rtl/tile_atlas_opacity_scan_macros.svh */
// Assertion macros for the tile atlas opacity scan.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef TILE_ATLAS_OPACITY_SCAN_MACROS_SVH
`define TILE_ATLAS_OPACITY_SCAN_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define TAOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define TAOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/taos_pkg.sv */
// Shared types and constants for the tile atlas opacity scan.
// No dependencies.
package taos_pkg;

  localparam int unsigned CFG_W        = 13;  // width of the size registers
  localparam int unsigned TILES        = 16;  // tiles along each side
  localparam int unsigned TILE_IDX_W   = 4;   // bits of one tile coordinate
  localparam int unsigned TILE_CNT_W   = 5;   // saturating tile counter, holds TILES
  localparam int unsigned ALPHA_W      = 8;
  localparam int unsigned OPAQUE_LIMIT = 250;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FORMAT = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_idx_e;

  // Where the current pixel falls, from the cursor to the tile logic
  typedef struct packed {
    logic                  in_tile;    // pixel belongs to one of the 16x16 tiles
    logic                  tile_end;   // bottom-right pixel of its tile
    logic                  frame_end;  // last pixel of the image
    logic [TILE_IDX_W-1:0] tx;
    logic [TILE_IDX_W-1:0] ty;
  } pos_t;

endpackage

/* rtl/taos_cursor.sv */
// Raster cursor: pixel and tile position counters for the opacity scan.
// Depends on taos_pkg.
module taos_cursor import taos_pkg::*; #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   restart_i,
  input  logic                                   advance_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0]          width_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0]          height_i,
  input  logic [$clog2(MAX_SIDE/TILES+1)-1:0]    side_i,
  output pos_t                                   pos_o
);

  localparam int unsigned DIM_W  = $clog2(MAX_SIDE+1);
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE/TILES+1);

  logic [DIM_W-1:0]      col_q, col_d, row_q, row_d;
  logic [SIDE_W-1:0]     sub_x_q, sub_x_d, sub_y_q, sub_y_d;
  logic [TILE_CNT_W-1:0] tx_q, tx_d, ty_q, ty_d;

  logic col_last, row_last, sub_x_last, sub_y_last;

  assign col_last   = (col_q == width_i - DIM_W'(1));
  assign row_last   = (row_q == height_i - DIM_W'(1));
  assign sub_x_last = (sub_x_q == side_i - SIDE_W'(1));
  assign sub_y_last = (sub_y_q == side_i - SIDE_W'(1));

  // Position of the current pixel
  assign pos_o.in_tile   = (side_i != '0) && (tx_q < TILE_CNT_W'(TILES))
                           && (ty_q < TILE_CNT_W'(TILES));
  assign pos_o.tile_end  = sub_x_last && sub_y_last;
  assign pos_o.frame_end = col_last && row_last;
  assign pos_o.tx        = tx_q[TILE_IDX_W-1:0];
  assign pos_o.ty        = ty_q[TILE_IDX_W-1:0];

  // Next position; tile counters stop at TILES
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    sub_x_d = sub_x_q;
    sub_y_d = sub_y_q;
    tx_d    = tx_q;
    ty_d    = ty_q;
    if (restart_i) begin
      col_d   = '0;
      row_d   = '0;
      sub_x_d = '0;
      sub_y_d = '0;
      tx_d    = '0;
      ty_d    = '0;
    end else if (advance_i) begin
      if (col_last) begin
        col_d   = '0;
        sub_x_d = '0;
        tx_d    = '0;
        if (row_last) begin
          row_d   = '0;
          sub_y_d = '0;
          ty_d    = '0;
        end else begin
          row_d = row_q + DIM_W'(1);
          if (sub_y_last) begin
            sub_y_d = '0;
            if (ty_q < TILE_CNT_W'(TILES)) ty_d = ty_q + TILE_CNT_W'(1);
          end else begin
            sub_y_d = sub_y_q + SIDE_W'(1);
          end
        end
      end else begin
        col_d = col_q + DIM_W'(1);
        if (sub_x_last) begin
          sub_x_d = '0;
          if (tx_q < TILE_CNT_W'(TILES)) tx_d = tx_q + TILE_CNT_W'(1);
        end else begin
          sub_x_d = sub_x_q + SIDE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sub_x_q <= '0;
      sub_y_q <= '0;
      tx_q    <= '0;
      ty_q    <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      sub_x_q <= sub_x_d;
      sub_y_q <= sub_y_d;
      tx_q    <= tx_d;
      ty_q    <= ty_d;
    end
  end

endmodule

/* rtl/tile_atlas_opacity_scan.sv */
// Tile atlas opacity scan: takes one alpha byte per beat in raster order and
// reports, in the cycle after each tile's bottom-right pixel, that tile's index and
// whether every alpha in it was at least 250. The tile side is width/16; the
// image splits into 16x16 tiles and pixels beyond them are ignored. If width/16
// and height/16 differ, or the format is not RGBA, tiles report non-opaque.
// Rate: one pixel per cycle, as the cursor and band update on every accepted pixel;
// a pending result stalls input only while the output side holds it off.
// Any configuration write restarts the scan at pixel zero.
// Depends on taos_pkg, taos_cursor and tile_atlas_opacity_scan_macros.svh.
`include "tile_atlas_opacity_scan_macros.svh"

module tile_atlas_opacity_scan import taos_pkg::*; #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ALPHA_W-1:0]    alpha_i,
  // tile results
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            tile_index_o,
  output logic                  opaque_o,
  output logic                  last_tile_o
);

  localparam int unsigned DIM_W  = $clog2(MAX_SIDE+1);
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE/TILES+1);
  localparam int unsigned CMP_W  = ((CFG_W > DIM_W) ? CFG_W : DIM_W) + 1;

  // Configuration registers
  logic [CFG_W-1:0] width_q, height_q;
  logic             rgba_q;
  logic             cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(TILES);
      height_q <= CFG_W'(TILES);
      rgba_q   <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_FORMAT: rgba_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp sizes to 1..MAX_SIDE and derive the tile side
  logic [DIM_W-1:0]  width_c, height_c;
  logic [SIDE_W-1:0] side;
  logic              img_ok;

  always_comb begin
    if (width_q == '0) begin
      width_c = DIM_W'(1);
    end else if (CMP_W'(width_q) > CMP_W'(MAX_SIDE)) begin
      width_c = DIM_W'(MAX_SIDE);
    end else begin
      width_c = DIM_W'(width_q);
    end
    if (height_q == '0) begin
      height_c = DIM_W'(1);
    end else if (CMP_W'(height_q) > CMP_W'(MAX_SIDE)) begin
      height_c = DIM_W'(MAX_SIDE);
    end else begin
      height_c = DIM_W'(height_q);
    end
  end

  assign side   = SIDE_W'(width_c >> 4);
  assign img_ok = ((width_c >> 4) == (height_c >> 4)) && rgba_q;

  // Handshake: a held result blocks input only while it is not taken
  logic in_acc;
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // Raster position
  pos_t pos;

  taos_cursor #(
    .MAX_SIDE (MAX_SIDE)
  ) u_cursor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_wr),
    .advance_i (in_acc),
    .width_i   (width_c),
    .height_i  (height_c),
    .side_i    (side),
    .pos_o     (pos)
  );

  // Band of per-column opaque bits and the result for a completed tile
  logic [TILES-1:0] band_q, band_d;
  logic             low_alpha, emit, op_bit;

  assign low_alpha = (alpha_i < ALPHA_W'(OPAQUE_LIMIT));
  assign emit      = in_acc && pos.in_tile && pos.tile_end;
  assign op_bit    = img_ok && band_q[pos.tx] && !low_alpha;

  always_comb begin
    band_d = band_q;
    if (cfg_wr) begin
      band_d = '1;
    end else if (in_acc) begin
      if (pos.in_tile) begin
        if (low_alpha) band_d[pos.tx] = 1'b0;
        if (pos.tile_end) band_d[pos.tx] = 1'b1;
      end
      if (pos.frame_end) band_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= '1;
    end else begin
      band_q <= band_d;
    end
  end

  // Result register
  logic       out_valid_q;
  logic [7:0] tile_index_q;
  logic       opaque_q, last_tile_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      tile_index_q <= {pos.ty, pos.tx};
      opaque_q     <= op_bit;
      last_tile_q  <= (&pos.ty) && (&pos.tx);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tile_index_o = tile_index_q;
  assign opaque_o     = opaque_q;
  assign last_tile_o  = last_tile_q;

  // Checks
  `TAOS_ASSERT_NEXT(a_emit_shows, emit, out_valid_o, "completed tile gave no result")
  `TAOS_ASSERT(a_no_overwrite, !(out_valid_o && !out_ready_i && in_ready_o),
               "input taken while result is stalled")
  `TAOS_ASSERT_NEXT(a_cfg_restart, cfg_wr, (pos.tx == '0) && (pos.ty == '0) && (&band_q),
                    "configuration write did not restart the scan")
  `TAOS_ASSERT_NEXT(a_frame_band, in_acc && pos.frame_end && !cfg_wr, &band_q,
                    "band not refilled at end of image")

endmodule

/* tb/tb_top.sv */
// Self-checking bench for tile_atlas_opacity_scan: random alpha streams over many image setups.
// Uses taos_pkg for types and register indexes. The expected tile results come from a
// tile-band scoreboard class built into this file.
module tb_top;
  import taos_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIDE_CAP    = 4096;
  localparam int unsigned PIXEL_TOTAL = 1350;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG    = 3000;
  localparam int unsigned SETTLE      = 4;

  typedef struct packed {
    logic [7:0] tile_index;
    logic       opaque;
    logic       last_tile;
  } tile_result_t;

  // Tile band scoreboard: mirrors the register file, the raster cursor and
  // the per-column opaque bits, and holds the tile results still to come
  class tile_scoreboard;
    logic [CFG_W-1:0] reg_width;
    logic [CFG_W-1:0] reg_height;
    logic             reg_rgba;
    int unsigned      col;
    int unsigned      row;
    logic [15:0]      band;
    tile_result_t     pending[$];
    int unsigned      errors;
    int unsigned      pixels;
    int unsigned      tiles;

    function new();
      reg_width  = 16;
      reg_height = 16;
      reg_rgba   = 1'b1;
      errors     = 0;
      pixels     = 0;
      tiles      = 0;
      restart();
    endfunction

    function void restart();
      col  = 0;
      row  = 0;
      band = '1;
    endfunction

    // zero counts as one, oversize saturates at the cap
    function int unsigned limit_side(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > SIDE_CAP) return SIDE_CAP;
      return v;
    endfunction

    // any register beat, spare index too, restarts the scan
    function void apply_reg(cfg_idx_e idx, logic [CFG_W-1:0] d);
      case (idx)
        CFG_WIDTH:  reg_width  = d;
        CFG_HEIGHT: reg_height = d;
        CFG_FORMAT: reg_rgba   = d[0];
        default: ;
      endcase
      restart();
    endfunction

    function void note_pixel(logic [ALPHA_W-1:0] a);
      int unsigned  w;
      int unsigned  h;
      int unsigned  side;
      int unsigned  tx;
      int unsigned  ty;
      logic         ok;
      tile_result_t r;
      w    = limit_side(reg_width);
      h    = limit_side(reg_height);
      side = w / TILES;
      ok   = (side == h / TILES) && reg_rgba;
      pixels++;
      if (col >= w || row >= h) restart();
      if (side != 0) begin
        tx = col / side;
        ty = row / side;
        if (tx < TILES && ty < TILES) begin
          if (a < OPAQUE_LIMIT) band[tx] = 1'b0;
          // bottom-right pixel closes the tile
          if (col % side == side - 1 && row % side == side - 1) begin
            r.tile_index = 8'(ty * TILES + tx);
            r.opaque     = ok && band[tx];
            r.last_tile  = (ty * TILES + tx) == 255;
            pending.push_back(r);
            band[tx] = 1'b1;
          end
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) begin
          row  = 0;
          band = '1;
        end
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_tile(logic [7:0] idx, logic op, logic last);
      tile_result_t e;
      tiles++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected tile %0d opaque %0b last %0b", idx, op, last));
      end else begin
        e = pending.pop_front();
        if (idx !== e.tile_index)
          report($sformatf("tile_index %0d, want %0d", idx, e.tile_index));
        if (op !== e.opaque)
          report($sformatf("tile %0d opaque %0b, want %0b", e.tile_index, op, e.opaque));
        if (last !== e.last_tile)
          report($sformatf("tile %0d last_tile %0b, want %0b", e.tile_index, last,
                           e.last_tile));
      end
    endtask
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i = CFG_WIDTH;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [ALPHA_W-1:0] alpha_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [7:0]       tile_index_o;
  logic             opaque_o;
  logic             last_tile_o;

  tile_scoreboard sb = new();

  int unsigned tx_max    = 0;
  int unsigned rx_max    = 0;
  bit          hold_req  = 1'b0;
  int unsigned holds     = 0;
  int unsigned setups    = 0;
  int unsigned quiet     = 0;

  always #5 clk_i = ~clk_i;

  tile_atlas_opacity_scan #(.MAX_SIDE(SIDE_CAP)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .alpha_i      (alpha_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tile_index_o (tile_index_o),
    .opaque_o     (opaque_o),
    .last_tile_o  (last_tile_o)
  );

  // Beat monitors: every accepted beat goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) sb.apply_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
    if (rst_ni && in_valid_i && in_ready_o) sb.note_pixel(alpha_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_tile(tile_index_o, opaque_o, last_tile_o);
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet <= 0;
    end else if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
                 (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, one long hold-off on request
  initial begin
    int unsigned gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        holds++;
      end
      gap = $urandom_range(0, rx_max);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  function automatic logic [ALPHA_W-1:0] draw_alpha();
    if ($urandom_range(0, 99) < 85) return ALPHA_W'($urandom_range(250, 255));
    return ALPHA_W'($urandom_range(0, 249));
  endfunction

  // valid stays high across back-to-back beats; lowered only for a gap
  task automatic send_pixel(logic [ALPHA_W-1:0] a);
    int unsigned gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    alpha_i    <= a;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic program_reg(cfg_idx_e idx, logic [CFG_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Wait for every pending tile, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One setup: drain, rewrite the registers, stream n random pixels
  task automatic run_setup(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic rgba,
                           int unsigned n);
    drain();
    if ($urandom_range(0, 3) == 0) program_reg(CFG_SPARE, CFG_W'($urandom()));
    program_reg(CFG_WIDTH, w);
    program_reg(CFG_HEIGHT, h);
    program_reg(CFG_FORMAT, {(CFG_W-1)'($urandom()), rgba});
    cfg_valid_i <= 1'b0;
    setups++;
    repeat (n) send_pixel(draw_alpha());
  endtask

  initial begin
    logic [ALPHA_W-1:0] edge_alphas[10];
    logic [CFG_W-1:0]   w;
    logic [CFG_W-1:0]   h;
    edge_alphas = '{8'd0, 8'd255, 8'd249, 8'd250, 8'd251, 8'd127, 8'd128, 8'd1, 8'd254, 8'd85};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset setup 16x16, threshold edges, then a spare-index restart
    foreach (edge_alphas[i]) send_pixel(edge_alphas[i]);
    drain();
    program_reg(CFG_SPARE, '1);
    cfg_valid_i <= 1'b0;
    foreach (edge_alphas[i]) send_pixel(edge_alphas[9 - i]);

    // Full 16x16 image past its last tile; receiver stalls once pixels flow
    fork
      run_setup(16, 16, 1'b1, 260);
      begin
        wait (setups != 0);
        hold_req = 1'b1;
      end
    join
    tx_max = 8;
    rx_max = 8;
    run_setup(32, 32, 1'b1, 140);          // tile side of two pixels
    tx_max = 0;
    run_setup(17, 17, 1'b1, 289);          // spare column and row ignored
    rx_max = 0;
    run_setup(48, 32, 1'b1, 150);          // side mismatch
    tx_max = 8;
    run_setup(16, 16, 1'b0, 60);           // not RGBA
    run_setup(15, 16, 1'b1, 40);           // width under sixteen
    run_setup(0, 0, 1'b1, 20);             // zero sizes count as one
    run_setup('1, '1, 1'b1, 20);           // oversize saturates
    rx_max = 8;
    run_setup(16, 0, 1'b1, 40);            // single-row image, mismatch
    run_setup(16, '1, 1'b1, 40);

    // Random setups, mostly small images
    while (sb.pixels < PIXEL_TOTAL) begin
      case ($urandom_range(0, 9))
        0:       w = CFG_W'($urandom_range(0, 15));
        1:       w = CFG_W'($urandom_range(4097, 8191));
        default: w = CFG_W'($urandom_range(16, 48));
      endcase
      h = ($urandom_range(0, 9) < 6) ? w : CFG_W'($urandom_range(0, 48));
      tx_max = $urandom_range(0, 1) ? 8 : 0;
      rx_max = $urandom_range(0, 1) ? 8 : 0;
      run_setup(w, h, $urandom_range(0, 5) != 0, (w > 48) ? 20 : $urandom_range(20, 160));
    end

    drain();
    repeat (10) @(posedge clk_i);
    while (sb.pending.size() != 0) begin
      sb.report($sformatf("tile %0d never arrived", sb.pending[0].tile_index));
      void'(sb.pending.pop_front());
    end
    $display("Covered %0d pixels and %0d tile results over %0d register setups.",
             sb.pixels, sb.tiles, setups);
    $display("Receiver hold-offs: %0d; mismatches: %0d.", holds, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
